@@ sv/quadrature_knob_led_position_macros.svh @@
// assertion macros for the quadrature knob led position block
// expects signals named clock and reset in the scope of each use
`ifndef QUADRATURE_KNOB_LED_POSITION_MACROS_SVH
`define QUADRATURE_KNOB_LED_POSITION_MACROS_SVH
`ifndef SYNTH
`define QK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define QK_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) cond |=> prop) else $error(msg);
`else
`define QK_ASSERT(lbl, prop, msg)
`define QK_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

@@ sv/qkled_pkg.sv @@
// shared constants and types for the quadrature knob led position block
// no dependencies
package qkled_pkg;

   localparam int LED_WIDTH_DEF  = 16;
   localparam int TIME_WIDTH_DEF = 32;

   // debounce register
   localparam int          DEB_W          = 31;
   localparam logic [30:0] DEBOUNCE_RESET = 31'd1000000;

   // register map
   localparam int          CSR_DATA_W     = 32;
   localparam int          CSR_ADDR_W     = 3;
   localparam logic [2:0]  CSR_DEBOUNCE_ADDR = 3'd0;

   // event kinds
   localparam logic OP_ENC = 1'b0;
   localparam logic OP_BTN = 1'b1;

   // button codes
   localparam logic [4:0] BTN_LEFT  = 5'd2;
   localparam logic [4:0] BTN_RIGHT = 5'd4;

   // quadrature phase codes on pins 1..0
   localparam logic [1:0] PH_00 = 2'd0;
   localparam logic [1:0] PH_01 = 2'd1;
   localparam logic [1:0] PH_10 = 2'd2;
   localparam logic [1:0] PH_11 = 2'd3;

   typedef enum logic [6:0] {
      PH_IDLE = 7'b0000001,
      PH_CW1  = 7'b0000010,
      PH_CW2  = 7'b0000100,
      PH_CW3  = 7'b0001000,
      PH_CCW1 = 7'b0010000,
      PH_CCW2 = 7'b0100000,
      PH_CCW3 = 7'b1000000
   } phase_type;

endpackage

@@ sv/quadrature_knob_led_position.sv @@
// path: a transaction is taken into the input register, and its result is written to the result register
// throughput: one transaction per cycle while rsp_stall is low; the input register and the result
//   register are parted, so a new event is taken while a result waits
// reset: synchronous, active high; position, saved position = 1, display on,
//   phase tracker idle, last press time 0, debounce interval 1000000 ticks
// depends on qkled_pkg, qkled_csr, qkled_core
module quadrature_knob_led_position #(
   parameter int LED_WIDTH  = qkled_pkg::LED_WIDTH_DEF,
   parameter int TIME_WIDTH = qkled_pkg::TIME_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [qkled_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [qkled_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [qkled_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   // event transactions
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [2:0]                         req_enc_pins,
   input  logic [4:0]                         req_button_pins,
   input  logic [TIME_WIDTH-1:0]              req_timestamp,
   // result transactions
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [LED_WIDTH-1:0]               rsp_led_drive,
   output logic                               rsp_display_enabled,
   output logic [LED_WIDTH-1:0]               rsp_led_position
);

   // debounce interval, held in the register file
   logic [qkled_pkg::DEB_W-1:0] debounce_ticks;

   // register file: one writable register at byte offset zero
   qkled_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .debounce_ticks (debounce_ticks)
   );

   // datapath: press debounce and display toggle first, then the
   // quadrature phase step, or a button rotation for button events
   qkled_core #(
      .LED_WIDTH  (LED_WIDTH),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .debounce_ticks      (debounce_ticks),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_enc_pins        (req_enc_pins),
      .req_button_pins     (req_button_pins),
      .req_timestamp       (req_timestamp),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_led_drive       (rsp_led_drive),
      .rsp_display_enabled (rsp_display_enabled),
      .rsp_led_position    (rsp_led_position)
   );

endmodule

@@ sv/qkled_csr.sv @@
// configuration register file: debounce interval
// depends on qkled_pkg
module qkled_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [qkled_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [qkled_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [qkled_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   output logic [qkled_pkg::DEB_W-1:0]        debounce_ticks
);

   logic [qkled_pkg::DEB_W-1:0] debounce_ff;
   logic [qkled_pkg::DEB_W-1:0] debounce_in;
   logic                        hit;

   assign hit        = (csr_paddr == qkled_pkg::CSR_DEBOUNCE_ADDR);
   assign csr_pready = 1'b1;

   always_comb begin
      debounce_in = debounce_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         debounce_in = csr_pwdata[qkled_pkg::DEB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= qkled_pkg::DEBOUNCE_RESET;
      end else begin
         debounce_ff <= debounce_in;
      end
   end

   assign csr_prdata     = hit ? qkled_pkg::CSR_DATA_W'(debounce_ff) : '0;
   assign debounce_ticks = debounce_ff;

endmodule

@@ sv/qkled_core.sv @@
// event datapath: input register, state update logic, result register
// depends on qkled_pkg and quadrature_knob_led_position_macros.svh
`include "quadrature_knob_led_position_macros.svh"
module qkled_core #(
   parameter int LED_WIDTH  = qkled_pkg::LED_WIDTH_DEF,
   parameter int TIME_WIDTH = qkled_pkg::TIME_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [qkled_pkg::DEB_W-1:0] debounce_ticks,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic [2:0]                  req_enc_pins,
   input  logic [4:0]                  req_button_pins,
   input  logic [TIME_WIDTH-1:0]       req_timestamp,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [LED_WIDTH-1:0]        rsp_led_drive,
   output logic                        rsp_display_enabled,
   output logic [LED_WIDTH-1:0]        rsp_led_position
);

   localparam int CmpW = (TIME_WIDTH > qkled_pkg::DEB_W) ? TIME_WIDTH : qkled_pkg::DEB_W;
   localparam logic [LED_WIDTH-1:0] LedTop = {1'b1, {(LED_WIDTH-1){1'b0}}};
   localparam logic [LED_WIDTH-1:0] LedOne = LED_WIDTH'(1);

   function automatic logic [LED_WIDTH-1:0] rot_left(input logic [LED_WIDTH-1:0] p);
      return p[LED_WIDTH-1] ? LedOne : {p[LED_WIDTH-2:0], 1'b0};
   endfunction

   function automatic logic [LED_WIDTH-1:0] rot_right(input logic [LED_WIDTH-1:0] p);
      return (p > LedOne) ? (p >> 1) : LedTop;
   endfunction

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic                  in_op_ff;
   logic [2:0]            in_enc_ff;
   logic [4:0]            in_btn_ff;
   logic [TIME_WIDTH-1:0] in_ts_ff;

   // tracker state
   qkled_pkg::phase_type  phase_ff, phase_in;
   logic [LED_WIDTH-1:0]  pos_ff, pos_in;
   logic [LED_WIDTH-1:0]  saved_ff, saved_in;
   logic                  shown_ff, shown_in;
   logic [TIME_WIDTH-1:0] last_ff, last_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [LED_WIDTH-1:0]  out_drive_ff;
   logic                  out_shown_ff;
   logic [LED_WIDTH-1:0]  out_pos_ff;

   logic                  take_in;
   logic                  adv;
   logic [TIME_WIDTH-1:0] diff;
   logic                  press_take;
   logic [LED_WIDTH-1:0]  pos_press;
   logic                  step_right, step_left;
   qkled_pkg::phase_type  phase_step;
   logic                  out_in_step;

   assign adv       = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign take_in   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_in) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
   end

   // debounce: wrapped difference read as signed, strictly above the interval
   assign diff       = in_ts_ff - last_ff;
   assign press_take = adv && (in_op_ff == qkled_pkg::OP_ENC) && in_enc_ff[2]
                       && !diff[TIME_WIDTH-1]
                       && (CmpW'(diff) > CmpW'(debounce_ticks));

   assign pos_press = (press_take && !shown_ff) ? saved_ff : pos_ff;

   // phase tracker
   always_comb begin
      phase_step = phase_ff;
      step_right = 1'b0;
      step_left  = 1'b0;
      case (phase_ff)
         qkled_pkg::PH_IDLE: begin
            if (in_enc_ff[1:0] == qkled_pkg::PH_01) phase_step = qkled_pkg::PH_CW1;
            else if (in_enc_ff[1:0] == qkled_pkg::PH_10) phase_step = qkled_pkg::PH_CCW1;
         end
         qkled_pkg::PH_CW1: begin
            if (in_enc_ff[1:0] == qkled_pkg::PH_00) phase_step = qkled_pkg::PH_CW2;
            else if (in_enc_ff[1:0] == qkled_pkg::PH_11) phase_step = qkled_pkg::PH_IDLE;
         end
         qkled_pkg::PH_CW2: begin
            if (in_enc_ff[1:0] == qkled_pkg::PH_10) phase_step = qkled_pkg::PH_CW3;
            else if (in_enc_ff[1:0] == qkled_pkg::PH_01) phase_step = qkled_pkg::PH_CW1;
         end
         qkled_pkg::PH_CW3: begin
            if (in_enc_ff[1:0] == qkled_pkg::PH_11) begin
               phase_step = qkled_pkg::PH_IDLE;
               step_right = 1'b1;
            end else if (in_enc_ff[1:0] == qkled_pkg::PH_00) begin
               phase_step = qkled_pkg::PH_CW2;
            end
         end
         qkled_pkg::PH_CCW1: begin
            if (in_enc_ff[1:0] == qkled_pkg::PH_00) phase_step = qkled_pkg::PH_CCW2;
            else if (in_enc_ff[1:0] == qkled_pkg::PH_11) phase_step = qkled_pkg::PH_IDLE;
         end
         qkled_pkg::PH_CCW2: begin
            if (in_enc_ff[1:0] == qkled_pkg::PH_01) phase_step = qkled_pkg::PH_CCW3;
            else if (in_enc_ff[1:0] == qkled_pkg::PH_10) phase_step = qkled_pkg::PH_CCW1;
         end
         qkled_pkg::PH_CCW3: begin
            if (in_enc_ff[1:0] == qkled_pkg::PH_11) begin
               phase_step = qkled_pkg::PH_IDLE;
               step_left  = 1'b1;
            end else if (in_enc_ff[1:0] == qkled_pkg::PH_00) begin
               phase_step = qkled_pkg::PH_CCW2;
            end
         end
         default: phase_step = phase_ff;
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      saved_in = saved_ff;
      shown_in = shown_ff;
      last_in  = last_ff;
      if (press_take) begin
         last_in  = in_ts_ff;
         shown_in = !shown_ff;
         if (shown_ff) saved_in = pos_ff;
      end
      if (adv) begin
         if (in_op_ff == qkled_pkg::OP_ENC) begin
            phase_in = phase_step;
            if (step_right)     pos_in = rot_right(pos_press);
            else if (step_left) pos_in = rot_left(pos_press);
            else                pos_in = pos_press;
         end else begin
            if (in_btn_ff == qkled_pkg::BTN_LEFT)       pos_in = rot_left(pos_ff);
            else if (in_btn_ff == qkled_pkg::BTN_RIGHT) pos_in = rot_right(pos_ff);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= qkled_pkg::PH_IDLE;
         pos_ff       <= LedOne;
         saved_ff     <= LedOne;
         shown_ff     <= 1'b1;
         last_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         saved_ff     <= saved_in;
         shown_ff     <= shown_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_op_ff  <= req_op;
         in_enc_ff <= req_enc_pins;
         in_btn_ff <= req_button_pins;
         in_ts_ff  <= req_timestamp;
      end
      if (adv) begin
         out_drive_ff <= shown_in ? pos_in : '0;
         out_shown_ff <= shown_in;
         out_pos_ff   <= pos_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_led_drive       = out_drive_ff;
   assign rsp_display_enabled = out_shown_ff;
   assign rsp_led_position    = out_pos_ff;

   assign out_in_step = (out_shown_ff == shown_ff) && (out_pos_ff == pos_ff);

   `QK_ASSERT(a_pos_onehot, $onehot(pos_ff), "position is not one-hot")
   `QK_ASSERT(a_stall_full, !req_stall || in_valid_ff, "stall with empty input register")
   `QK_ASSERT_NEXT(a_adv_result, adv, out_valid_ff, "advanced item left no result")
   `QK_ASSERT(a_out_tracks, !out_valid_ff || out_in_step, "result register out of step")

endmodule
